>>> src/bkd_pkg.sv
// Shared types, sizes and codes for the bounded key deque.
package bkd_pkg;

    localparam int DEPTH   = 32;
    localparam int KEY_W   = 31;
    localparam int MODE_W  = 4;
    localparam int KIND_W  = 2;
    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int OCC_PAD = KEY_W - CNT_W;

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

    // result kinds
    localparam logic [KIND_W-1:0] KIND_ELEM    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_NONE    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_BLANK   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_EMPTY_L = 2'd3;

    typedef enum logic [MODE_W-1:0] {
        MODE_ADD_FRONT   = 4'd0,
        MODE_ADD_REAR    = 4'd1,
        MODE_DROP_FIRST  = 4'd2,
        MODE_DROP_LAST   = 4'd3,
        MODE_DELETE_KEY  = 4'd4,
        MODE_PRINT_ALL   = 4'd5,
        MODE_PRINT_FIRST = 4'd6,
        MODE_PRINT_LAST  = 4'd7,
        MODE_CLEAR       = 4'd8
    } mode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_SEARCH_RD,
        ST_SEARCH_CHK,
        ST_EMIT_RD,
        ST_EMIT_WR,
        ST_SINGLE
    } state_t;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic [KEY_W-1:0] wdata;
        logic             re;
        logic [IDX_W-1:0] raddr;
    } mem_req_t;

    typedef struct packed {
        logic             eq;
        logic             lt;
        logic [KEY_W-1:0] diff;
    } cmp_res_t;

    typedef struct packed {
        logic              valid;
        logic [KEY_W-1:0]  key;
        logic [KIND_W-1:0] kind;
        logic              last;
    } emit_t;

endpackage

>>> src/bkd_store.sv
// Key storage: one write port, one read port with registered read data.
module bkd_store (
    input  logic                           clk,
    input  bkd_pkg::mem_req_t              req,
    output logic [bkd_pkg::KEY_W-1:0]      rdata
);

    logic [bkd_pkg::KEY_W-1:0] mem [bkd_pkg::DEPTH];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata <= mem[req.raddr];
        end
    end

endmodule

>>> src/bkd_cmp.sv
// Shared compare and subtract unit: equality, less-than and difference.
module bkd_cmp (
    input  logic [bkd_pkg::KEY_W-1:0] a,
    input  logic [bkd_pkg::KEY_W-1:0] b,
    output bkd_pkg::cmp_res_t         res
);

    logic [bkd_pkg::KEY_W:0] sub;

    assign sub      = {1'b0, a} - {1'b0, b};
    assign res.eq   = (a == b);
    assign res.lt   = sub[bkd_pkg::KEY_W];
    assign res.diff = sub[bkd_pkg::KEY_W-1:0];

endmodule

>>> src/bkd_ctrl.sv
// Sequencer: decodes a request and walks the store one entry at a time.
module bkd_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [bkd_pkg::MODE_W-1:0]    mode,
    input  logic [bkd_pkg::KEY_W-1:0]     value,
    input  logic                          slot_free,
    output bkd_pkg::emit_t                emit,
    output bkd_pkg::mem_req_t             mem_req,
    input  logic [bkd_pkg::KEY_W-1:0]     rdata
);

    bkd_pkg::state_t              state_reg, state_next;
    logic [bkd_pkg::MODE_W-1:0]   mode_reg, mode_next;
    logic [bkd_pkg::KEY_W-1:0]    value_reg, value_next;
    logic [bkd_pkg::CNT_W-1:0]    occ_reg, occ_next;
    logic [bkd_pkg::CNT_W-1:0]    ptr_reg, ptr_next;
    logic [bkd_pkg::CNT_W-1:0]    end_reg, end_next;
    logic                         up_reg, up_next;
    logic [bkd_pkg::KIND_W-1:0]   skind_reg, skind_next;

    logic [bkd_pkg::CNT_W-1:0]    ptr_inc, ptr_dec, occ_inc, occ_dec;
    logic [bkd_pkg::KEY_W-1:0]    cmp_a;
    bkd_pkg::cmp_res_t            cmp;

    assign ptr_inc = ptr_reg + 1'b1;
    assign ptr_dec = ptr_reg - 1'b1;
    assign occ_inc = occ_reg + 1'b1;
    assign occ_dec = occ_reg - 1'b1;

    // one unit serves the window check and the key search
    assign cmp_a = (state_reg == bkd_pkg::ST_DISPATCH)
                 ? {{bkd_pkg::OCC_PAD{1'b0}}, occ_reg} : rdata;

    bkd_cmp u_cmp (
        .a   (cmp_a),
        .b   (value_reg),
        .res (cmp)
    );

    assign in_ready = (state_reg == bkd_pkg::ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bkd_pkg::ST_IDLE;
            occ_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            occ_reg   <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg  <= mode_next;
        value_reg <= value_next;
        ptr_reg   <= ptr_next;
        end_reg   <= end_next;
        up_reg    <= up_next;
        skind_reg <= skind_next;
    end

    always_comb
    begin
        state_next = state_reg;
        mode_next  = mode_reg;
        value_next = value_reg;
        occ_next   = occ_reg;
        ptr_next   = ptr_reg;
        end_next   = end_reg;
        up_next    = up_reg;
        skind_next = skind_reg;
        mem_req    = '0;
        emit       = '0;

        unique case (state_reg)
            bkd_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    mode_next  = mode;
                    value_next = value;
                    state_next = bkd_pkg::ST_DISPATCH;
                end
            end

            bkd_pkg::ST_DISPATCH:
            begin
                state_next = bkd_pkg::ST_IDLE;
                unique case (mode_reg)
                    bkd_pkg::MODE_ADD_FRONT:
                    begin
                        if (occ_reg < bkd_pkg::DEPTH_CNT)
                        begin
                            ptr_next   = occ_reg;
                            up_next    = 1'b1;
                            state_next = bkd_pkg::ST_SHIFT_RD;
                        end
                    end
                    bkd_pkg::MODE_ADD_REAR:
                    begin
                        if (occ_reg < bkd_pkg::DEPTH_CNT)
                        begin
                            mem_req.we    = 1'b1;
                            mem_req.waddr = occ_reg[bkd_pkg::IDX_W-1:0];
                            mem_req.wdata = value_reg;
                            occ_next      = occ_inc;
                        end
                    end
                    bkd_pkg::MODE_DROP_FIRST:
                    begin
                        if (occ_reg != '0)
                        begin
                            ptr_next   = {{(bkd_pkg::CNT_W-1){1'b0}}, 1'b1};
                            up_next    = 1'b0;
                            state_next = bkd_pkg::ST_SHIFT_RD;
                        end
                    end
                    bkd_pkg::MODE_DROP_LAST:
                    begin
                        if (occ_reg != '0)
                        begin
                            occ_next = occ_dec;
                        end
                    end
                    bkd_pkg::MODE_DELETE_KEY:
                    begin
                        ptr_next   = '0;
                        state_next = bkd_pkg::ST_SEARCH_RD;
                    end
                    bkd_pkg::MODE_PRINT_ALL:
                    begin
                        if (occ_reg == '0)
                        begin
                            skind_next = bkd_pkg::KIND_NONE;
                            state_next = bkd_pkg::ST_SINGLE;
                        end
                        else
                        begin
                            ptr_next   = '0;
                            end_next   = occ_reg;
                            state_next = bkd_pkg::ST_EMIT_RD;
                        end
                    end
                    bkd_pkg::MODE_PRINT_FIRST:
                    begin
                        ptr_next = '0;
                        priority if (occ_reg == '0)
                        begin
                            skind_next = bkd_pkg::KIND_NONE;
                            state_next = bkd_pkg::ST_SINGLE;
                        end
                        else if (cmp.lt)
                        begin
                            end_next   = occ_reg;
                            state_next = bkd_pkg::ST_EMIT_RD;
                        end
                        else if (value_reg == '0)
                        begin
                            skind_next = bkd_pkg::KIND_BLANK;
                            state_next = bkd_pkg::ST_SINGLE;
                        end
                        else
                        begin
                            end_next   = value_reg[bkd_pkg::CNT_W-1:0];
                            state_next = bkd_pkg::ST_EMIT_RD;
                        end
                    end
                    bkd_pkg::MODE_PRINT_LAST:
                    begin
                        end_next = occ_reg;
                        priority if (cmp.lt && occ_reg == '0)
                        begin
                            skind_next = bkd_pkg::KIND_NONE;
                            state_next = bkd_pkg::ST_SINGLE;
                        end
                        else if (cmp.lt)
                        begin
                            ptr_next   = '0;
                            state_next = bkd_pkg::ST_EMIT_RD;
                        end
                        else if (occ_reg == '0)
                        begin
                            skind_next = bkd_pkg::KIND_EMPTY_L;
                            state_next = bkd_pkg::ST_SINGLE;
                        end
                        else if (value_reg == '0)
                        begin
                            skind_next = bkd_pkg::KIND_BLANK;
                            state_next = bkd_pkg::ST_SINGLE;
                        end
                        else
                        begin
                            ptr_next   = cmp.diff[bkd_pkg::CNT_W-1:0];
                            state_next = bkd_pkg::ST_EMIT_RD;
                        end
                    end
                    bkd_pkg::MODE_CLEAR:
                    begin
                        occ_next = '0;
                    end
                    default:
                    begin
                        state_next = bkd_pkg::ST_IDLE;
                    end
                endcase
            end

            bkd_pkg::ST_SHIFT_RD:
            begin
                if (up_reg)
                begin
                    if (ptr_reg == '0)
                    begin
                        // room made at the front: place the new key
                        mem_req.we    = 1'b1;
                        mem_req.waddr = '0;
                        mem_req.wdata = value_reg;
                        occ_next      = occ_inc;
                        state_next    = bkd_pkg::ST_IDLE;
                    end
                    else
                    begin
                        mem_req.re    = 1'b1;
                        mem_req.raddr = ptr_dec[bkd_pkg::IDX_W-1:0];
                        state_next    = bkd_pkg::ST_SHIFT_WR;
                    end
                end
                else
                begin
                    if (ptr_reg >= occ_reg)
                    begin
                        occ_next   = occ_dec;
                        state_next = bkd_pkg::ST_IDLE;
                    end
                    else
                    begin
                        mem_req.re    = 1'b1;
                        mem_req.raddr = ptr_reg[bkd_pkg::IDX_W-1:0];
                        state_next    = bkd_pkg::ST_SHIFT_WR;
                    end
                end
            end

            bkd_pkg::ST_SHIFT_WR:
            begin
                mem_req.we    = 1'b1;
                mem_req.wdata = rdata;
                if (up_reg)
                begin
                    mem_req.waddr = ptr_reg[bkd_pkg::IDX_W-1:0];
                    ptr_next      = ptr_dec;
                end
                else
                begin
                    mem_req.waddr = ptr_dec[bkd_pkg::IDX_W-1:0];
                    ptr_next      = ptr_inc;
                end
                state_next = bkd_pkg::ST_SHIFT_RD;
            end

            bkd_pkg::ST_SEARCH_RD:
            begin
                if (ptr_reg >= occ_reg)
                begin
                    state_next = bkd_pkg::ST_IDLE;
                end
                else
                begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = ptr_reg[bkd_pkg::IDX_W-1:0];
                    state_next    = bkd_pkg::ST_SEARCH_CHK;
                end
            end

            bkd_pkg::ST_SEARCH_CHK:
            begin
                ptr_next = ptr_inc;
                if (cmp.eq)
                begin
                    // close the gap above the match
                    up_next    = 1'b0;
                    state_next = bkd_pkg::ST_SHIFT_RD;
                end
                else
                begin
                    state_next = bkd_pkg::ST_SEARCH_RD;
                end
            end

            bkd_pkg::ST_EMIT_RD:
            begin
                mem_req.re    = 1'b1;
                mem_req.raddr = ptr_reg[bkd_pkg::IDX_W-1:0];
                state_next    = bkd_pkg::ST_EMIT_WR;
            end

            bkd_pkg::ST_EMIT_WR:
            begin
                if (slot_free)
                begin
                    emit.valid = 1'b1;
                    emit.key   = rdata;
                    emit.kind  = bkd_pkg::KIND_ELEM;
                    emit.last  = (ptr_inc == end_reg);
                    ptr_next   = ptr_inc;
                    state_next = (ptr_inc == end_reg) ? bkd_pkg::ST_IDLE
                                                      : bkd_pkg::ST_EMIT_RD;
                end
            end

            bkd_pkg::ST_SINGLE:
            begin
                if (slot_free)
                begin
                    emit.valid = 1'b1;
                    emit.key   = '0;
                    emit.kind  = skind_reg;
                    emit.last  = 1'b1;
                    state_next = bkd_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = bkd_pkg::ST_IDLE;
            end
        endcase
    end

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= bkd_pkg::DEPTH_CNT)
        else $error("occupancy above depth");

    a_emit_slot: assert property (@(posedge clk) disable iff (!rst_n)
        emit.valid |-> slot_free)
        else $error("result pushed into a full output register");

    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bkd_pkg::ST_IDLE) |-> (!mem_req.we && !mem_req.re))
        else $error("store accessed while idle");

    a_wr_bound: assert property (@(posedge clk) disable iff (!rst_n)
        mem_req.we |-> (int'(mem_req.waddr) < bkd_pkg::DEPTH))
        else $error("store write beyond depth");

    a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == bkd_pkg::ST_DISPATCH))
        else $error("accepted request not dispatched");

endmodule

>>> src/bounded_key_deque_with_delete_top.sv
// Top level of the bounded key deque with delete by key.
//
//  channel | signals                        | direction | carries
//  --------+--------------------------------+-----------+---------------------------
//  in      | in_valid, in_ready, mode, value | into block | one operation request
//  out     | out_valid, out_ready, key,     | out of    | one result per request
//          | kind, last                     | block     | step, last marks the end
//
// Each request is taken in idle and decoded in dispatch, where add rear,
// drop last and clear finish; add front shifts each entry up by a read and
// a write, then places the key; drop first shifts the tail down; delete key
// reads and checks each entry searched, then shifts the tail. Prints give
// one result per entry, each a registered read through the single read
// port. Reset clears the count, control state and output valid flag; the
// store needs no pass. Stalls: a full output register holds the sequencer;
// a new request is taken once the sequencer is idle, even if a result waits.
module bounded_key_deque_with_delete_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [bkd_pkg::MODE_W-1:0]    mode,
    input  logic [bkd_pkg::KEY_W-1:0]     value,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [bkd_pkg::KEY_W-1:0]     key,
    output logic [bkd_pkg::KIND_W-1:0]    kind,
    output logic                          last
);

    bkd_pkg::emit_t             emit;
    bkd_pkg::mem_req_t          mem_req;
    logic [bkd_pkg::KEY_W-1:0]  rdata;
    logic                       slot_free;

    logic                       out_valid_reg, out_valid_next;
    logic [bkd_pkg::KEY_W-1:0]  key_reg, key_next;
    logic [bkd_pkg::KIND_W-1:0] kind_reg, kind_next;
    logic                       last_reg, last_next;

    // the output register is free when empty or being drained this cycle
    assign slot_free = !out_valid_reg || out_ready;

    bkd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (mode),
        .value     (value),
        .slot_free (slot_free),
        .emit      (emit),
        .mem_req   (mem_req),
        .rdata     (rdata)
    );

    bkd_store u_store (
        .clk   (clk),
        .req   (mem_req),
        .rdata (rdata)
    );

    // load a new result, drop a taken one, otherwise hold
    always_comb
    begin
        out_valid_next = out_valid_reg;
        key_next       = key_reg;
        kind_next      = kind_reg;
        last_next      = last_reg;
        priority if (emit.valid)
        begin
            out_valid_next = 1'b1;
            key_next       = emit.key;
            kind_next      = emit.kind;
            last_next      = emit.last;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg  <= key_next;
        kind_reg <= kind_next;
        last_reg <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign key       = key_reg;
    assign kind      = kind_reg;
    assign last      = last_reg;

endmodule
